### hw/rtl/pnn_pkg.sv
// shared types, widths and the newell edge function for the polygon normal core
package pnn_pkg;

  localparam int COORD_BITS   = 16;
  localparam int MAX_VERTICES = 64;
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int TERM_W       = 2 * (COORD_BITS + 1);
  localparam int NSUM_W       = 40;
  localparam int HALF_W       = NSUM_W / 2;
  localparam int CSUM_W       = COORD_BITS + CNT_W - 1;
  localparam int D_W          = COORD_BITS + CNT_W + 2;
  localparam int DPROD_W      = HALF_W + 1 + D_W;
  localparam int DOT_W        = 66;
  localparam int NORM_W       = 16;
  localparam int UN_W         = 30;
  localparam int SQ_W         = 64;
  localparam int Q_W          = 15;
  localparam int NUM_W        = UN_W + Q_W;
  localparam int DV_W         = NUM_W + 1;

  typedef logic [2:0][COORD_BITS-1:0] coord3_t;
  typedef logic [2:0][TERM_W-1:0]     term3_t;
  typedef logic [2:0][NSUM_W-1:0]     nsum3_t;
  typedef logic [2:0][CSUM_W-1:0]     csum3_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic signed [COORD_BITS-1:0] vertex_z;
    logic signed [COORD_BITS-1:0] inside_x;
    logic signed [COORD_BITS-1:0] inside_y;
    logic signed [COORD_BITS-1:0] inside_z;
    logic                         last_vertex;
  } pnn_in_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;
    logic                     reversed;
  } pnn_out_t;

  // one closed-off polygon handed from the front to the back
  typedef struct packed {
    nsum3_t           nsum;
    coord3_t          prev;
    coord3_t          first;
    csum3_t           csum;
    logic [CNT_W-1:0] cnt;
    coord3_t          ref_pt;
  } pnn_job_t;

  // newell cross terms of the edge a -> b
  function automatic term3_t newell_edge(coord3_t a, coord3_t b);
    logic signed [COORD_BITS:0] dx, dy, dz, sx, sy, sz;
    term3_t t;
    dx = $signed(a[0]) - $signed(b[0]);
    dy = $signed(a[1]) - $signed(b[1]);
    dz = $signed(a[2]) - $signed(b[2]);
    sx = $signed(a[0]) + $signed(b[0]);
    sy = $signed(a[1]) + $signed(b[1]);
    sz = $signed(a[2]) + $signed(b[2]);
    t[0] = dy * sz;
    t[1] = dz * sx;
    t[2] = dx * sy;
    return t;
  endfunction

endpackage

### hw/rtl/polygon_newell_normal_core.sv
// polygon normal core: newell accumulation front, job queue, normalizing back end
//
//  channel | handshake               | payload
//  --------+-------------------------+--------------------------------------
//  in      | in_valid_i / in_ready_o | in_req_i: vertex, inside point, last
//  out     | out_valid_o/out_ready_i | out_req_o: q1.14 normal, reversed
//
// vertices are taken one per cycle while the queue has a free slot
// the back end's time per polygon is set by the normalizing shift loop,
// the one-bit-a-cycle square root and the 15-step divider, all skipped for a zero normal
// the queue holds two finished polygons, so the front keeps taking vertices
// while the back works; a stalled output only holds the back in its last step
// reset clears the front's sums, the queue and the output valid
module polygon_newell_normal_core import pnn_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  pnn_in_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output pnn_out_t out_req_o
);

  logic     push, full, pop, job_valid;
  pnn_job_t job_in, job_out;

  pnn_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .q_full_i   (full),
    .push_o     (push),
    .job_o      (job_in)
  );

  pnn_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .job_o   (job_out)
  );

  pnn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o)
  );

endmodule

### hw/rtl/pnn_front.sv
// front end: takes vertices, accumulates newell and coordinate sums, emits one job per polygon
module pnn_front import pnn_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  pnn_in_t  in_req_i,
  input  logic     q_full_i,
  output logic     push_o,
  output pnn_job_t job_o
);

  coord3_t          first_q, first_d, prev_q, prev_d, v, ins;
  nsum3_t           nsum_q, nsum_d;
  csum3_t           csum_q, csum_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  term3_t           t;
  logic             take;

  assign in_ready_o = !q_full_i;
  assign take       = in_valid_i && in_ready_o;
  assign push_o     = take && in_req_i.last_vertex;

  always_comb begin
    v[0]   = in_req_i.vertex_x;
    v[1]   = in_req_i.vertex_y;
    v[2]   = in_req_i.vertex_z;
    ins[0] = in_req_i.inside_x;
    ins[1] = in_req_i.inside_y;
    ins[2] = in_req_i.inside_z;
    t      = newell_edge(prev_q, v);
    first_d = first_q;
    prev_d  = prev_q;
    nsum_d  = nsum_q;
    csum_d  = csum_q;
    cnt_d   = cnt_q;
    // vertices beyond the limit are dropped
    if (cnt_q < CNT_W'(MAX_VERTICES)) begin
      if (cnt_q == '0) begin
        first_d = v;
      end else begin
        for (int i = 0; i < 3; i++) begin
          nsum_d[i] = nsum_q[i] + NSUM_W'($signed(t[i]));
        end
      end
      prev_d = v;
      for (int i = 0; i < 3; i++) begin
        csum_d[i] = csum_q[i] + CSUM_W'($signed(v[i]));
      end
      cnt_d = cnt_q + 1'b1;
    end
    job_o.nsum   = nsum_d;
    job_o.prev   = prev_d;
    job_o.first  = first_d;
    job_o.csum   = csum_d;
    job_o.cnt    = cnt_d;
    job_o.ref_pt = ins;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= '0;
      prev_q  <= '0;
      nsum_q  <= '0;
      csum_q  <= '0;
      cnt_q   <= '0;
    end else if (take) begin
      if (in_req_i.last_vertex) begin
        first_q <= '0;
        prev_q  <= '0;
        nsum_q  <= '0;
        csum_q  <= '0;
        cnt_q   <= '0;
      end else begin
        first_q <= first_d;
        prev_q  <= prev_d;
        nsum_q  <= nsum_d;
        csum_q  <= csum_d;
        cnt_q   <= cnt_d;
      end
    end
  end

endmodule

### hw/rtl/pnn_queue.sv
// two-entry job queue between front and back
module pnn_queue import pnn_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  pnn_job_t job_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output pnn_job_t job_o
);

  pnn_job_t   mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

### hw/rtl/pnn_back.sv
// back end: closing edge, orientation test, normalization, square root and division
module pnn_back import pnn_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     job_valid_i,
  input  pnn_job_t job_i,
  output logic     pop_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output pnn_out_t out_req_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_CLOSE, S_DVEC, S_DOT, S_FLIP, S_MAX, S_NORM,
    S_SQ, S_SQRT, S_DINIT, S_DIV, S_OUT
  } state_e;

  state_e                     state_q;
  pnn_job_t                   job_q;
  nsum3_t                     n_q, u_q;
  logic [2:0][D_W-1:0]        d_q;
  logic [2:0]                 nsign_q;
  logic [NSUM_W-1:0]          m_q;
  logic                       rev_q;
  logic signed [DPROD_W-1:0]  dprod_q;
  logic                       dhi_q;
  logic signed [DOT_W-1:0]    acc_q;
  logic [2*UN_W-1:0]          sprod_q;
  logic [SQ_W-1:0]            s_q, x_q, r_q, bit_q;
  logic [NUM_W-1:0]           num_q;
  logic [DV_W-1:0]            dv_q;
  logic [Q_W-1:0]             quo_q;
  logic [3:0]                 step_q;
  logic [1:0]                 axis_q;
  logic [2:0][NORM_W-1:0]     res_q;
  logic                       out_valid_q;
  pnn_out_t                   out_q;

  term3_t                     t;
  logic signed [D_W-1:0]      cp [3];
  logic [1:0]                 dax;
  logic signed [HALF_W:0]     mop;
  logic signed [DPROD_W-1:0]  dprod;
  nsum3_t                     nv, uv;
  logic [NSUM_W-1:0]          mx;
  logic [2*UN_W-1:0]          sprod;
  logic [SQ_W-1:0]            rb;
  logic                       ge;
  logic [Q_W-1:0]             qn;
  logic [NORM_W-1:0]          qs;

  assign pop_o       = (state_q == S_IDLE) && job_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  always_comb begin
    t = newell_edge(job_q.prev, job_q.first);
    for (int i = 0; i < 3; i++) begin
      cp[i] = $signed({1'b0, job_q.cnt}) * $signed(job_q.ref_pt[i]);
    end
    // dot product: low then high half of each normal component
    dax = step_q[2:1];
    if (step_q[0]) begin
      mop = $signed(n_q[dax][NSUM_W-1:HALF_W]);
    end else begin
      mop = $signed({1'b0, n_q[dax][HALF_W-1:0]});
    end
    dprod = mop * $signed(d_q[dax]);
    for (int i = 0; i < 3; i++) begin
      nv[i] = acc_q[DOT_W-1] ? -n_q[i] : n_q[i];
      uv[i] = nv[i][NSUM_W-1] ? -nv[i] : nv[i];
    end
    mx = u_q[0];
    if (u_q[1] > mx) mx = u_q[1];
    if (u_q[2] > mx) mx = u_q[2];
    sprod = u_q[step_q[1:0]][UN_W-1:0] * u_q[step_q[1:0]][UN_W-1:0];
    rb = r_q + bit_q;
    ge = num_q >= NUM_W'(dv_q);
    qn = {quo_q[Q_W-2:0], ge};
    qs = nsign_q[axis_q] ? -NORM_W'(qn) : NORM_W'(qn);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      axis_q      <= '0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (job_valid_i) begin
            job_q   <= job_i;
            n_q     <= job_i.nsum;
            state_q <= S_CLOSE;
          end
        end
        S_CLOSE: begin
          for (int i = 0; i < 3; i++) begin
            n_q[i] <= n_q[i] + NSUM_W'($signed(t[i]));
          end
          state_q <= S_DVEC;
        end
        S_DVEC: begin
          for (int i = 0; i < 3; i++) begin
            d_q[i] <= D_W'($signed(job_q.csum[i])) - cp[i];
          end
          acc_q   <= '0;
          step_q  <= '0;
          state_q <= S_DOT;
        end
        S_DOT: begin
          if (step_q != 4'd6) begin
            dprod_q <= dprod;
            dhi_q   <= step_q[0];
          end
          if (step_q != 4'd0) begin
            if (dhi_q) begin
              acc_q <= acc_q + (DOT_W'(dprod_q) <<< HALF_W);
            end else begin
              acc_q <= acc_q + DOT_W'(dprod_q);
            end
          end
          if (step_q == 4'd6) begin
            state_q <= S_FLIP;
          end
          step_q <= step_q + 1'b1;
        end
        S_FLIP: begin
          rev_q <= acc_q[DOT_W-1];
          for (int i = 0; i < 3; i++) begin
            nsign_q[i] <= nv[i][NSUM_W-1];
            u_q[i]     <= uv[i];
          end
          state_q <= S_MAX;
        end
        S_MAX: begin
          m_q <= mx;
          if (mx == '0) begin
            res_q   <= '0;
            state_q <= S_OUT;
          end else begin
            state_q <= S_NORM;
          end
        end
        S_NORM: begin
          if (m_q[NSUM_W-1:UN_W] != '0) begin
            m_q <= m_q >> 1;
            for (int i = 0; i < 3; i++) u_q[i] <= u_q[i] >> 1;
          end else if (!m_q[UN_W-1]) begin
            m_q <= m_q << 1;
            for (int i = 0; i < 3; i++) u_q[i] <= u_q[i] << 1;
          end else begin
            s_q     <= '0;
            step_q  <= '0;
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          if (step_q != 4'd3) begin
            sprod_q <= sprod;
            step_q  <= step_q + 1'b1;
          end
          if (step_q != 4'd0) begin
            s_q <= s_q + SQ_W'(sprod_q);
          end
          if (step_q == 4'd3) begin
            x_q     <= s_q + SQ_W'(sprod_q);
            r_q     <= '0;
            bit_q   <= SQ_W'(1) << (SQ_W - 2);
            state_q <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (bit_q != '0) begin
            if (x_q >= rb) begin
              x_q <= x_q - rb;
              r_q <= (r_q >> 1) + bit_q;
            end else begin
              r_q <= r_q >> 1;
            end
            bit_q <= bit_q >> 2;
          end else begin
            axis_q  <= '0;
            state_q <= S_DINIT;
          end
        end
        S_DINIT: begin
          num_q   <= (NUM_W'(u_q[axis_q][UN_W-1:0]) << (Q_W - 1))
                     + NUM_W'(r_q[UN_W+1:1]);
          dv_q    <= DV_W'(r_q[UN_W+1:0]) << (Q_W - 1);
          quo_q   <= '0;
          step_q  <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (ge) begin
            num_q <= num_q - NUM_W'(dv_q);
          end
          quo_q  <= qn;
          dv_q   <= dv_q >> 1;
          step_q <= step_q + 1'b1;
          if (step_q == 4'(Q_W - 1)) begin
            res_q[axis_q] <= qs;
            if (axis_q == 2'd2) begin
              state_q <= S_OUT;
            end else begin
              axis_q  <= axis_q + 1'b1;
              state_q <= S_DINIT;
            end
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.normal_x <= res_q[0];
            out_q.normal_y <= res_q[1];
            out_q.normal_z <= res_q[2];
            out_q.reversed <= rev_q;
            out_valid_q    <= 1'b1;
            state_q        <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SQ) |-> (m_q[NSUM_W-1:UN_W] == '0 && m_q[UN_W-1]))
    else $error("normalized maximum out of range");
  a_sqrt_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SQRT && bit_q == '0) |-> (r_q[SQ_W-1:UN_W+2] == '0))
    else $error("square root grew too wide");
  a_unit_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |->
      ($signed(out_q.normal_x) <= 16384 && $signed(out_q.normal_x) >= -16384 &&
       $signed(out_q.normal_y) <= 16384 && $signed(out_q.normal_y) >= -16384 &&
       $signed(out_q.normal_z) <= 16384 && $signed(out_q.normal_z) >= -16384))
    else $error("normal component beyond unit length");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q == S_CLOSE))
    else $error("job taken without starting work");
`endif

endmodule
